// ----- hw/rtl/multichannel_fir_filter_unit_assert.svh -----
// Assertion macros shared by the filter modules.
// Each macro expects a clock i_clk and an active-low reset i_rst_n in scope.
`ifndef MULTICHANNEL_FIR_FILTER_UNIT_ASSERT_SVH
`define MULTICHANNEL_FIR_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define MFIR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MFIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/mfir_pkg.sv -----
package mfir_pkg;

    // Sample and coefficient format.
    localparam int SAMPLE_W  = 16;
    localparam int CH_W      = 3;
    localparam int FRAC_BITS = 15;

    // Coefficient register file.
    localparam int NCOEF      = 8;
    localparam int CFG_ADDR_W = 4;

    // Product of two samples plus growth for up to eight taps.
    localparam int PROD_W = 2 * SAMPLE_W;
    localparam int ACC_W  = PROD_W + 3;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);

    // Input item.
    typedef struct packed {
        logic [CH_W-1:0]            channel;
        logic signed [SAMPLE_W-1:0] sample_in;
    } t_in;

    // Result item.
    typedef struct packed {
        logic [CH_W-1:0]            channel_out;
        logic signed [SAMPLE_W-1:0] sample_out;
    } t_out;

    // Token that travels along the row of cells.
    typedef struct packed {
        logic                       valid;
        logic                       live;
        logic [CH_W-1:0]            ch;
        logic signed [SAMPLE_W-1:0] carry;
        logic signed [ACC_W-1:0]    acc;
    } t_tok;

    // Drop the fraction bits (round toward minus infinity) and saturate.
    function automatic logic signed [SAMPLE_W-1:0] sat_q15(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] q;
        q = acc >>> FRAC_BITS;
        if (q > SAT_HI) begin
            q = SAT_HI;
        end else if (q < SAT_LO) begin
            q = SAT_LO;
        end
        return SAMPLE_W'(q);
    endfunction

endpackage

// ----- hw/rtl/mfir_cell.sv -----
`include "multichannel_fir_filter_unit_assert.svh"

module mfir_cell #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mfir_pkg::t_tok                       i_tok,
    output logic                                 o_ready,
    input  logic signed [mfir_pkg::SAMPLE_W-1:0] i_coef,
    output mfir_pkg::t_tok                       o_tok,
    input  logic                                 i_ready
);

    localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // One delay-line entry of this tap for every channel.
    logic [NUM_CHANNELS-1:0][mfir_pkg::SAMPLE_W-1:0] r_hist;
    mfir_pkg::t_tok                                  r_tok;
    mfir_pkg::t_tok                                  n_tok;

    logic                                 en;
    logic                                 hist_we;
    logic [CW-1:0]                        idx;
    logic signed [mfir_pkg::SAMPLE_W-1:0] old;
    logic signed [mfir_pkg::PROD_W-1:0]   prod;

    // The cell takes a token when its own output register is free or draining.
    assign o_ready = !r_tok.valid || i_ready;
    assign en      = i_tok.valid && o_ready;
    assign hist_we = en && i_tok.live;
    assign idx     = CW'(i_tok.ch);
    assign old     = r_hist[idx];
    assign prod    = i_coef * i_tok.carry;

    // The incoming sample is this tap's sample; the displaced one moves on.
    always_comb begin
        n_tok = i_tok;
        if (i_tok.live) begin
            n_tok.acc   = i_tok.acc + mfir_pkg::ACC_W'(prod);
            n_tok.carry = old;
        end
    end

    // Delay-line storage and the token register towards the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist      <= '0;
            r_tok.valid <= 1'b0;
        end else begin
            if (hist_we) begin
                r_hist[idx] <= i_tok.carry;
            end
            if (o_ready) begin
                r_tok.valid <= i_tok.valid;
            end
        end
        if (en) begin
            r_tok.live  <= n_tok.live;
            r_tok.ch    <= n_tok.ch;
            r_tok.carry <= n_tok.carry;
            r_tok.acc   <= n_tok.acc;
        end
    end

    assign o_tok = r_tok;

    `MFIR_ASSERT_NEXT(a_dead_keeps_hist, en && !i_tok.live, $stable(r_hist), "history changed")
    `MFIR_ASSERT_NEXT(a_take_fills, en, r_tok.valid, "token lost in cell")
    `MFIR_ASSERT_NEXT(a_hist_write, hist_we, r_hist[$past(idx)] == $past(i_tok.carry), "lost write")

endmodule

// ----- hw/rtl/multichannel_fir_filter_unit.sv -----
// Path: an input transfer passes through the token register of every cell and then the
// output register before the result appears on o_valid. Throughput: one item per cycle
// while the output does not stall; each tap cell owns one multiply-accumulate and passes
// its partial sum to the next cell, so a new item may follow every cycle. Output back-pressure
// holds only the cells that carry a token; empty cells keep accepting. Reset (synchronous,
// active low) clears all delay lines and coefficients and empties the row and output register.
`include "multichannel_fir_filter_unit_assert.svh"

module multichannel_fir_filter_unit #(
    parameter int TAPS         = 8,
    parameter int NUM_CHANNELS = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  mfir_pkg::t_in                          i_data,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output mfir_pkg::t_out                         o_data,
    input  logic                                   i_cfg_we,
    input  logic [mfir_pkg::CFG_ADDR_W-1:0]        i_cfg_addr,
    input  logic [mfir_pkg::SAMPLE_W-1:0]          i_cfg_wdata
);

    logic signed [mfir_pkg::SAMPLE_W-1:0] r_coef [mfir_pkg::NCOEF];
    mfir_pkg::t_tok                       tok [TAPS+1];
    logic                                 rdy [TAPS+1];
    logic                                 r_o_valid;
    mfir_pkg::t_out                       r_o_data;
    logic                                 out_take;
    logic                                 out_dead;

    // Coefficient registers; writes to unknown indices are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mfir_pkg::NCOEF; i++) begin
                r_coef[i] <= '0;
            end
        end else if (i_cfg_we && (int'(i_cfg_addr) < mfir_pkg::NCOEF)) begin
            r_coef[i_cfg_addr[$clog2(mfir_pkg::NCOEF)-1:0]] <= i_cfg_wdata;
        end
    end

    // Token entering the first cell.
    assign tok[0].valid = i_valid;
    assign tok[0].live  = int'(i_data.channel) < NUM_CHANNELS;
    assign tok[0].ch    = i_data.channel;
    assign tok[0].carry = i_data.sample_in;
    assign tok[0].acc   = '0;
    assign o_ready      = rdy[0];

    // Row of tap cells.
    for (genvar m = 0; m < TAPS; m++) begin : g_cell
        mfir_cell #(
            .NUM_CHANNELS(NUM_CHANNELS)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_tok  (tok[m]),
            .o_ready(rdy[m]),
            .i_coef (r_coef[m]),
            .o_tok  (tok[m+1]),
            .i_ready(rdy[m+1])
        );
    end

    // Output register: scale, saturate and hold the result until its transfer.
    assign rdy[TAPS] = !r_o_valid || i_ready;
    assign out_take  = tok[TAPS].valid && rdy[TAPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (rdy[TAPS]) begin
            r_o_valid <= tok[TAPS].valid;
        end
        if (out_take) begin
            r_o_data.channel_out <= tok[TAPS].ch;
            r_o_data.sample_out  <= tok[TAPS].live ? mfir_pkg::sat_q15(tok[TAPS].acc) : '0;
        end
    end

    assign o_valid  = r_o_valid;
    assign o_data   = r_o_data;
    assign out_dead = int'(o_data.channel_out) >= NUM_CHANNELS;

    `MFIR_ASSERT_NOW(a_dead_zero, o_valid && out_dead, o_data.sample_out == '0, "dead channel nonzero")
    `MFIR_ASSERT_NEXT(a_out_load, out_take, r_o_valid, "result lost at output")

endmodule

// ----- verif/multichannel_fir_filter_unit_test.sv -----
`timescale 1ns / 1ps

module multichannel_fir_filter_unit_test;

    localparam int TAPS         = 8;
    localparam int NUM_CHANNELS = 8;
    localparam int RAND_PER_SET = 150;

    // Register indexes of the coefficient file; indexes from REG_UNUSED up are not mapped.
    localparam logic [mfir_pkg::CFG_ADDR_W-1:0] REG_COEF_0 = '0;
    localparam logic [mfir_pkg::CFG_ADDR_W-1:0] REG_UNUSED =
        mfir_pkg::CFG_ADDR_W'(mfir_pkg::NCOEF);
    localparam logic [mfir_pkg::CFG_ADDR_W-1:0] REG_LAST   = {mfir_pkg::CFG_ADDR_W{1'b1}};

    typedef enum int {
        COEF_RANDOM,
        COEF_ALL_MIN,
        COEF_ALL_MAX,
        COEF_ONE_TAP,
        COEF_SMALL
    } t_coef_set;

    // Tracks the filter state and queues the filtered sample each transfer should produce.
    class t_filtered_sample_tracker;
        logic signed [mfir_pkg::SAMPLE_W-1:0] coefs[mfir_pkg::NCOEF];
        logic signed [mfir_pkg::SAMPLE_W-1:0] delay_line[NUM_CHANNELS][TAPS];
        int unsigned                          wr_pos[NUM_CHANNELS];
        mfir_pkg::t_out                       pending_outputs[$];
        int                                   mismatches;

        function new();
            mismatches = 0;
            foreach (coefs[i]) coefs[i] = '0;
            foreach (wr_pos[c]) wr_pos[c] = 0;
            foreach (delay_line[c, t]) delay_line[c][t] = '0;
        endfunction

        function void write_reg(input logic [mfir_pkg::CFG_ADDR_W-1:0] idx,
                                input logic [mfir_pkg::SAMPLE_W-1:0] data);
            if (idx < mfir_pkg::NCOEF) begin
                coefs[idx[$clog2(mfir_pkg::NCOEF)-1:0]] = data;
            end
        endfunction

        function void note_transfer(input mfir_pkg::t_in item);
            mfir_pkg::t_out res;
            int unsigned    ch;
            int unsigned    p;
            longint         acc;
            longint         q;
            ch  = item.channel;
            q   = 0;
            if (ch < NUM_CHANNELS) begin
                p = wr_pos[ch];
                delay_line[ch][p] = item.sample_in;
                acc = 0;
                for (int m = 0; m < TAPS && m < mfir_pkg::NCOEF; m++) begin
                    acc += longint'(coefs[m]) * longint'(delay_line[ch][(p + TAPS - m) % TAPS]);
                end
                // Arithmetic shift rounds toward minus infinity, then clamp to 16 bits.
                q = acc >>> mfir_pkg::FRAC_BITS;
                if (q > 32767) begin
                    q = 32767;
                end else if (q < -32768) begin
                    q = -32768;
                end
                wr_pos[ch] = (p + 1) % TAPS;
            end
            res.channel_out = item.channel;
            res.sample_out  = q[mfir_pkg::SAMPLE_W-1:0];
            pending_outputs.push_back(res);
        endfunction

        function void check_transfer(input mfir_pkg::t_out got);
            mfir_pkg::t_out want;
            if (pending_outputs.size() == 0) begin
                $display("%0t: unexpected result channel %0d sample %0d", $time,
                         got.channel_out, got.sample_out);
                mismatches++;
                return;
            end
            want = pending_outputs.pop_front();
            if (got.channel_out !== want.channel_out) begin
                $display("%0t: channel_out expected %0d actual %0d", $time,
                         want.channel_out, got.channel_out);
                mismatches++;
            end
            if (got.sample_out !== want.sample_out) begin
                $display("%0t: sample_out expected %0d actual %0d", $time,
                         want.sample_out, got.sample_out);
                mismatches++;
            end
        endfunction

        function int pending();
            return pending_outputs.size();
        endfunction
    endclass

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_valid     = 1'b0;
    logic                            o_ready;
    mfir_pkg::t_in                   i_data      = '0;
    logic                            o_valid;
    logic                            i_ready     = 1'b0;
    mfir_pkg::t_out                  o_data;
    logic                            i_cfg_we    = 1'b0;
    logic [mfir_pkg::CFG_ADDR_W-1:0] i_cfg_addr  = '0;
    logic [mfir_pkg::SAMPLE_W-1:0]   i_cfg_wdata = '0;

    t_filtered_sample_tracker tracker;
    int unsigned              send_idle_pct = 0;
    int unsigned              recv_idle_pct = 0;

    multichannel_fir_filter_unit #(
        .TAPS        (TAPS),
        .NUM_CHANNELS(NUM_CHANNELS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // Offer one sample, with an optional random gap first, and wait for its transfer.
    task automatic send_sample(input mfir_pkg::t_in item);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= item;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        tracker.note_transfer(item);
    endtask

    task automatic send_fixed(input int ch, input int value);
        mfir_pkg::t_in item;
        item.channel   = mfir_pkg::CH_W'(ch);
        item.sample_in = mfir_pkg::SAMPLE_W'(value);
        send_sample(item);
    endtask

    // Stop offering samples and let the pipeline empty completely.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (TAPS + 4) @(posedge i_clk);
    endtask

    // Write all coefficients of one set, then one write to an unmapped index.
    task automatic load_coefs(input t_coef_set kind);
        logic [mfir_pkg::SAMPLE_W-1:0]   value;
        logic [mfir_pkg::CFG_ADDR_W-1:0] idx;
        int                              hot;
        hot = $urandom_range(TAPS - 1);
        for (int m = 0; m < mfir_pkg::NCOEF; m++) begin
            case (kind)
                COEF_ALL_MIN: value = 16'h8000;
                COEF_ALL_MAX: value = 16'h7fff;
                COEF_ONE_TAP: value = (m == hot) ? 16'h7fff : 16'h0000;
                COEF_SMALL:   value = mfir_pkg::SAMPLE_W'($urandom_range(2048) - 1024);
                default:      value = mfir_pkg::SAMPLE_W'($urandom);
            endcase
            idx          = mfir_pkg::CFG_ADDR_W'(REG_COEF_0 + m);
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= idx;
            i_cfg_wdata <= value;
            tracker.write_reg(idx, value);
            @(posedge i_clk);
        end
        idx          = mfir_pkg::CFG_ADDR_W'($urandom_range(REG_LAST, REG_UNUSED));
        value        = mfir_pkg::SAMPLE_W'($urandom);
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        tracker.write_reg(idx, value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic mfir_pkg::t_in random_sample();
        mfir_pkg::t_in item;
        item.channel = mfir_pkg::CH_W'($urandom_range(NUM_CHANNELS - 1));
        case ($urandom_range(9))
            0:       item.sample_in = 16'sh8000;
            1:       item.sample_in = 16'sh7fff;
            2:       item.sample_in = mfir_pkg::SAMPLE_W'($urandom_range(8) - 4);
            default: item.sample_in = mfir_pkg::SAMPLE_W'($urandom);
        endcase
        return item;
    endfunction

    // Receiver: stalls at random and checks every result transfer.
    initial begin
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                tracker.check_transfer(o_data);
            end
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Main sequence.
    initial begin
        tracker = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: saturation in both directions and one sample on every channel, including the extremes.
        send_idle_pct = 7;
        recv_idle_pct = 54;
        load_coefs(COEF_ALL_MAX);
        repeat (TAPS) send_fixed(0, 32767);
        repeat (TAPS) send_fixed(1, -32768);
        send_fixed(2, 0);
        send_fixed(3, -1);
        send_fixed(4, 1);
        send_fixed(5, 32767);
        send_fixed(6, -32768);
        send_fixed(7, 16'h5555);
        drain();

        // Random part: three idling modes, each over several coefficient sets.
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    send_idle_pct = 7;
                    recv_idle_pct = 54;
                end
                1: begin
                    send_idle_pct = 54;
                    recv_idle_pct = 7;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int k = 0; k < 3; k++) begin
                load_coefs(t_coef_set'((mode * 3 + k) % 5));
                repeat (RAND_PER_SET) send_sample(random_sample());
                drain();
            end
        end

        if (tracker.pending() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, tracker.pending());
        end
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("multichannel_fir_filter_unit_test OK");
        end else begin
            $display("multichannel_fir_filter_unit_test NOT OK");
        end
        $finish;
    end

    // Watchdog for a stuck handshake.
    initial begin
        #1_000_000;
        $display("multichannel_fir_filter_unit_test NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/mfir_pkg.sv
hw/rtl/mfir_cell.sv
hw/rtl/multichannel_fir_filter_unit.sv
verif/multichannel_fir_filter_unit_test.sv
